/* src/tsm_pkg.sv */
package tsm_pkg;

   localparam int RAW_BITS       = 12;
   localparam int COORD_BITS     = 16;
   localparam int PROD_BITS      = 2 * COORD_BITS;
   localparam int DIV_STEPS      = COORD_BITS;
   localparam int AXIS_LATENCY   = 3 + DIV_STEPS + 1;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [COORD_BITS-1:0] RESET_OFFSET = 16'd300;
   localparam logic [COORD_BITS-1:0] RESET_SPAN   = 16'd3600;
   localparam logic [2:0]            RESET_ORIENT = 3'd3;
   localparam logic [COORD_BITS-1:0] RESET_WIDTH  = 16'd320;
   localparam logic [COORD_BITS-1:0] RESET_HEIGHT = 16'd240;

   localparam int ORIENT_SWAP     = 0;
   localparam int ORIENT_MIRROR_X = 1;
   localparam int ORIENT_MIRROR_Y = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_X_OFFSET      = 3'd0,
      CSR_X_SPAN        = 3'd1,
      CSR_Y_OFFSET      = 3'd2,
      CSR_Y_SPAN        = 3'd3,
      CSR_ORIENT_FLAGS  = 3'd4,
      CSR_SCREEN_WIDTH  = 3'd5,
      CSR_SCREEN_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [RAW_BITS-1:0] raw_x;
      logic [RAW_BITS-1:0] raw_y;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] screen_x;
      logic [COORD_BITS-1:0] screen_y;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_offset;
      logic [COORD_BITS-1:0] x_span;
      logic [COORD_BITS-1:0] y_offset;
      logic [COORD_BITS-1:0] y_span;
      logic [2:0]            orient_flags;
      logic [COORD_BITS-1:0] screen_width;
      logic [COORD_BITS-1:0] screen_height;
   } cfg_type;

endpackage

/* src/tsm_csr.sv */
module tsm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tsm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tsm_pkg::COORD_BITS-1:0]       csr_data,
   output tsm_pkg::cfg_type                     cfg
);

   tsm_pkg::cfg_type                cfg_ff;
   logic [tsm_pkg::COORD_BITS-1:0]  nonzero_in;

   assign csr_ready  = 1'b1;
   assign nonzero_in = (csr_data == '0) ? tsm_pkg::COORD_BITS'(1) : csr_data;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_offset      <= tsm_pkg::RESET_OFFSET;
         cfg_ff.x_span        <= tsm_pkg::RESET_SPAN;
         cfg_ff.y_offset      <= tsm_pkg::RESET_OFFSET;
         cfg_ff.y_span        <= tsm_pkg::RESET_SPAN;
         cfg_ff.orient_flags  <= tsm_pkg::RESET_ORIENT;
         cfg_ff.screen_width  <= tsm_pkg::RESET_WIDTH;
         cfg_ff.screen_height <= tsm_pkg::RESET_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tsm_pkg::CSR_X_OFFSET:      cfg_ff.x_offset      <= csr_data;
            tsm_pkg::CSR_X_SPAN:        cfg_ff.x_span        <= nonzero_in;
            tsm_pkg::CSR_Y_OFFSET:      cfg_ff.y_offset      <= csr_data;
            tsm_pkg::CSR_Y_SPAN:        cfg_ff.y_span        <= nonzero_in;
            tsm_pkg::CSR_ORIENT_FLAGS:  cfg_ff.orient_flags  <= csr_data[2:0];
            tsm_pkg::CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= nonzero_in;
            tsm_pkg::CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= nonzero_in;
            default: ;
         endcase
      end
   end

endmodule

/* src/tsm_axis.sv */
module tsm_axis (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic [tsm_pkg::RAW_BITS-1:0]         src,
   input  logic [tsm_pkg::COORD_BITS-1:0]       offset,
   input  logic [tsm_pkg::COORD_BITS-1:0]       span,
   input  logic [tsm_pkg::COORD_BITS-1:0]       size,
   input  logic                                 mirror,
   output logic [tsm_pkg::COORD_BITS-1:0]       coord
);

   localparam int CW = tsm_pkg::COORD_BITS;
   localparam int NS = tsm_pkg::DIV_STEPS;

   logic [CW:0]                    diff_in;
   logic [CW-1:0]                  mag_ff;
   logic                           sub_neg_ff;
   logic [CW-1:0]                  size_m1;
   logic [tsm_pkg::PROD_BITS-1:0]  prod_ff;
   logic                           mul_neg_ff;
   logic [CW-1:0]                  rem_ff [0:NS];
   logic [CW-1:0]                  lo_ff  [0:NS];
   logic                           neg_ff [0:NS];
   logic                           ovf_ff [0:NS];
   logic [CW-1:0]                  clip_in;
   logic [CW-1:0]                  coord_ff;

   assign size_m1 = size - CW'(1);
   assign diff_in = {1'b0, CW'(src)} - {1'b0, offset};

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff     <= diff_in[CW-1:0];
         sub_neg_ff <= diff_in[CW];
         prod_ff    <= tsm_pkg::PROD_BITS'(mag_ff) * tsm_pkg::PROD_BITS'(size_m1);
         mul_neg_ff <= sub_neg_ff;
         rem_ff[0]  <= prod_ff[tsm_pkg::PROD_BITS-1:CW];
         lo_ff[0]   <= prod_ff[CW-1:0];
         neg_ff[0]  <= mul_neg_ff;
         ovf_ff[0]  <= prod_ff[tsm_pkg::PROD_BITS-1:CW] >= span;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_div
      logic [CW:0] trial;
      logic        fits;

      assign trial = {rem_ff[k], lo_ff[k][CW-1]};
      assign fits  = trial >= {1'b0, span};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= fits ? CW'(trial - {1'b0, span}) : trial[CW-1:0];
            lo_ff[k+1]  <= {lo_ff[k][CW-2:0], fits};
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   always_comb begin
      if (neg_ff[NS]) begin
         clip_in = '0;
      end else if (ovf_ff[NS] || lo_ff[NS] >= size) begin
         clip_in = size_m1;
      end else begin
         clip_in = lo_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         coord_ff <= mirror ? size_m1 - clip_in : clip_in;
      end
   end

   assign coord = coord_ff;

endmodule

/* src/touch_raw_to_screen_mapper.sv */
// Maps a raw touch sample pair to screen pixels: optional axis swap, then per
// axis (raw - offset) * (size - 1) / span, truncated, clamped to the screen,
// optionally mirrored. One request is accepted every cycle while the result
// channel does not stall; each result passes through the offset subtract,
// the 16x16 multiply, the overflow check and sixteen restoring-divide stages
// (one quotient bit each) plus the output register. Backpressure on the
// result channel stalls the whole pipeline. Configuration writes are always
// accepted and registered, and must be made while no request is in flight.
module touch_raw_to_screen_mapper (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tsm_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tsm_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tsm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tsm_pkg::COORD_BITS-1:0]       csr_data
);

   localparam int LAT = tsm_pkg::AXIS_LATENCY;

   tsm_pkg::cfg_type               cfg;
   logic                           enable;
   logic [tsm_pkg::RAW_BITS-1:0]   src_x;
   logic [tsm_pkg::RAW_BITS-1:0]   src_y;
   logic [LAT-1:0]                 valid_ff;
   logic [LAT-1:0]                 valid_in;

   tsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign enable    = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = valid_ff[LAT-1];

   assign src_x = cfg.orient_flags[tsm_pkg::ORIENT_SWAP] ? req_payload.raw_y
                                                         : req_payload.raw_x;
   assign src_y = cfg.orient_flags[tsm_pkg::ORIENT_SWAP] ? req_payload.raw_x
                                                         : req_payload.raw_y;

   assign valid_in = {valid_ff[LAT-2:0], req_valid && req_ready};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   tsm_axis u_axis_x (
      .clock  (clock),
      .enable (enable),
      .src    (src_x),
      .offset (cfg.x_offset),
      .span   (cfg.x_span),
      .size   (cfg.screen_width),
      .mirror (cfg.orient_flags[tsm_pkg::ORIENT_MIRROR_X]),
      .coord  (rsp_payload.screen_x)
   );

   tsm_axis u_axis_y (
      .clock  (clock),
      .enable (enable),
      .src    (src_y),
      .offset (cfg.y_offset),
      .span   (cfg.y_span),
      .size   (cfg.screen_height),
      .mirror (cfg.orient_flags[tsm_pkg::ORIENT_MIRROR_Y]),
      .coord  (rsp_payload.screen_y)
   );

endmodule

/* verif/touch_raw_to_screen_mapper_tb.sv */
`timescale 1ns / 100ps

module touch_raw_to_screen_mapper_tb;

   localparam logic [tsm_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int MAX_REPORTS   = 10;
   localparam int DRAIN_CYCLES  = tsm_pkg::AXIS_LATENCY + 5;
   localparam int ITEMS_PER_CAL = 42;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   tsm_pkg::req_type                   req_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   tsm_pkg::rsp_type                   rsp_payload;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [tsm_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [tsm_pkg::COORD_BITS-1:0]     csr_data = '0;

   tsm_pkg::cfg_type calib;
   tsm_pkg::rsp_type screen_points_due [$];
   int               mismatch_count = 0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;

   touch_raw_to_screen_mapper i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [tsm_pkg::COORD_BITS-1:0] at_least_one(
      logic [tsm_pkg::COORD_BITS-1:0] v);
      return (v == '0) ? 16'd1 : v;
   endfunction

   function automatic logic [tsm_pkg::COORD_BITS-1:0] scale_axis(
      logic [tsm_pkg::RAW_BITS-1:0]   raw,
      logic [tsm_pkg::COORD_BITS-1:0] off,
      logic [tsm_pkg::COORD_BITS-1:0] span,
      logic [tsm_pkg::COORD_BITS-1:0] size,
      logic                           mirror);
      longint raw_l, off_l, span_l, size_l, quot;
      logic [tsm_pkg::COORD_BITS-1:0] pix;
      raw_l  = longint'(raw);
      off_l  = longint'(off);
      span_l = longint'(span);
      size_l = longint'(size);
      quot   = (raw_l - off_l) * (size_l - 1) / span_l;
      if (quot < 0)
         pix = '0;
      else if (quot >= size_l)
         pix = size - 16'd1;
      else
         pix = quot[tsm_pkg::COORD_BITS-1:0];
      if (mirror)
         pix = size - 16'd1 - pix;
      return pix;
   endfunction

   function automatic tsm_pkg::rsp_type map_to_screen(tsm_pkg::req_type s);
      logic [tsm_pkg::RAW_BITS-1:0] src_x, src_y;
      tsm_pkg::rsp_type p;
      src_x = calib.orient_flags[tsm_pkg::ORIENT_SWAP] ? s.raw_y : s.raw_x;
      src_y = calib.orient_flags[tsm_pkg::ORIENT_SWAP] ? s.raw_x : s.raw_y;
      p.screen_x = scale_axis(src_x, calib.x_offset, calib.x_span, calib.screen_width,
                              calib.orient_flags[tsm_pkg::ORIENT_MIRROR_X]);
      p.screen_y = scale_axis(src_y, calib.y_offset, calib.y_span, calib.screen_height,
                              calib.orient_flags[tsm_pkg::ORIENT_MIRROR_Y]);
      return p;
   endfunction

   function automatic void apply_register(logic [tsm_pkg::CSR_INDEX_BITS-1:0] idx,
                                          logic [tsm_pkg::COORD_BITS-1:0] data);
      case (idx)
         tsm_pkg::CSR_X_OFFSET:      calib.x_offset      = data;
         tsm_pkg::CSR_X_SPAN:        calib.x_span        = at_least_one(data);
         tsm_pkg::CSR_Y_OFFSET:      calib.y_offset      = data;
         tsm_pkg::CSR_Y_SPAN:        calib.y_span        = at_least_one(data);
         tsm_pkg::CSR_ORIENT_FLAGS:  calib.orient_flags  = data[2:0];
         tsm_pkg::CSR_SCREEN_WIDTH:  calib.screen_width  = at_least_one(data);
         tsm_pkg::CSR_SCREEN_HEIGHT: calib.screen_height = at_least_one(data);
         default: ;
      endcase
   endfunction

   function automatic logic [tsm_pkg::COORD_BITS-1:0] edge_or_any16();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic tsm_pkg::cfg_type random_calibration();
      tsm_pkg::cfg_type c;
      if ($urandom_range(2) != 0) begin
         c.x_offset      = 16'($urandom_range(50, 500));
         c.x_span        = 16'($urandom_range(2500, 3900));
         c.y_offset      = 16'($urandom_range(50, 500));
         c.y_span        = 16'($urandom_range(2500, 3900));
         c.screen_width  = 16'($urandom_range(64, 1024));
         c.screen_height = 16'($urandom_range(64, 1024));
      end else begin
         c.x_offset      = edge_or_any16();
         c.x_span        = edge_or_any16();
         c.y_offset      = edge_or_any16();
         c.y_span        = edge_or_any16();
         c.screen_width  = edge_or_any16();
         c.screen_height = edge_or_any16();
      end
      c.orient_flags = 3'($urandom_range(7));
      return c;
   endfunction

   function automatic tsm_pkg::req_type random_sample();
      tsm_pkg::req_type s;
      s.raw_x = tsm_pkg::RAW_BITS'($urandom);
      s.raw_y = tsm_pkg::RAW_BITS'($urandom);
      if ($urandom_range(7) == 0)
         s.raw_x = $urandom_range(1) ? '1 : '0;
      if ($urandom_range(7) == 0)
         s.raw_y = $urandom_range(1) ? '1 : '0;
      return s;
   endfunction

   // hold csr_valid high across back-to-back writes; caller drops it
   task automatic write_reg(logic [tsm_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [tsm_pkg::COORD_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
   endtask

   task automatic load_calibration(tsm_pkg::cfg_type c);
      write_reg(tsm_pkg::CSR_X_OFFSET, c.x_offset);
      write_reg(tsm_pkg::CSR_X_SPAN, c.x_span);
      write_reg(tsm_pkg::CSR_Y_OFFSET, c.y_offset);
      write_reg(tsm_pkg::CSR_Y_SPAN, c.y_span);
      write_reg(tsm_pkg::CSR_ORIENT_FLAGS, {13'($urandom), c.orient_flags});
      write_reg(tsm_pkg::CSR_SCREEN_WIDTH, c.screen_width);
      write_reg(tsm_pkg::CSR_SCREEN_HEIGHT, c.screen_height);
      csr_valid <= 1'b0;
   endtask

   // keep req_valid high into the next request unless a gap is drawn
   task automatic send_sample(tsm_pkg::req_type s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (!req_ready);
      screen_points_due.push_back(map_to_screen(s));
   endtask

   task automatic send_raw(logic [tsm_pkg::RAW_BITS-1:0] rx,
                           logic [tsm_pkg::RAW_BITS-1:0] ry);
      tsm_pkg::req_type s;
      s.raw_x = rx;
      s.raw_y = ry;
      send_sample(s);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (screen_points_due.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      tsm_pkg::rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (screen_points_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected request result: x=%0d y=%0d",
                        rsp_payload.screen_x, rsp_payload.screen_y);
         end else begin
            due = screen_points_due.pop_front();
            if (rsp_payload.screen_x !== due.screen_x ||
                rsp_payload.screen_y !== due.screen_y) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                           due.screen_x, due.screen_y,
                           rsp_payload.screen_x, rsp_payload.screen_y);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic test_reset_mapping();
      send_raw(12'd0, 12'd0);
      send_raw(12'd4095, 12'd4095);
      send_raw(12'd0, 12'd4095);
      send_raw(12'd4095, 12'd0);
      send_raw(12'd300, 12'd300);
      send_raw(12'd3900, 12'd3899);
      settle();
   endtask

   task automatic test_orientation_flags();
      for (int o = 0; o < 8; o++) begin
         write_reg(tsm_pkg::CSR_ORIENT_FLAGS, {13'($urandom), 3'(o)});
         csr_valid <= 1'b0;
         send_raw(12'd1000, 12'd3000);
         settle();
      end
   endtask

   task automatic test_zero_registers();
      write_reg(tsm_pkg::CSR_X_SPAN, 16'd0);
      write_reg(tsm_pkg::CSR_Y_SPAN, 16'd0);
      write_reg(tsm_pkg::CSR_SCREEN_WIDTH, 16'd0);
      write_reg(tsm_pkg::CSR_SCREEN_HEIGHT, 16'd0);
      csr_valid <= 1'b0;
      send_raw(12'd4095, 12'd0);
      send_raw(12'd123, 12'd3456);
      settle();
      write_reg(tsm_pkg::CSR_SCREEN_WIDTH, 16'd320);
      write_reg(CSR_UNUSED_INDEX, 16'hFFFF);
      csr_valid <= 1'b0;
      send_raw(12'd4095, 12'd4095);
      settle();
   endtask

   task automatic test_register_extremes();
      tsm_pkg::cfg_type c;
      c.x_offset      = 16'd0;
      c.x_span        = 16'd1;
      c.screen_width  = 16'hFFFF;
      c.y_offset      = 16'hFFFF;
      c.y_span        = 16'hFFFF;
      c.screen_height = 16'hFFFF;
      c.orient_flags  = 3'd0;
      load_calibration(c);
      send_raw(12'd4095, 12'd4095);
      send_raw(12'd1, 12'd0);
      send_raw(12'd0, 12'd0);
      settle();
   endtask

   task automatic test_random_traffic();
      int idle_plan [4][2] = '{'{0, 0}, '{69, 0}, '{0, 69}, '{38, 38}};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_plan[ph][0];
         recv_stall_pct = idle_plan[ph][1];
         for (int r = 0; r < 5; r++) begin
            load_calibration(random_calibration());
            for (int n = 0; n < ITEMS_PER_CAL; n++)
               send_sample(random_sample());
            settle();
         end
      end
   endtask

   initial begin
      calib.x_offset      = tsm_pkg::RESET_OFFSET;
      calib.x_span        = tsm_pkg::RESET_SPAN;
      calib.y_offset      = tsm_pkg::RESET_OFFSET;
      calib.y_span        = tsm_pkg::RESET_SPAN;
      calib.orient_flags  = tsm_pkg::RESET_ORIENT;
      calib.screen_width  = tsm_pkg::RESET_WIDTH;
      calib.screen_height = tsm_pkg::RESET_HEIGHT;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_mapping();
      test_orientation_flags();
      test_zero_registers();
      test_register_extremes();
      test_random_traffic();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (screen_points_due.size() != 0)
         $display("results still outstanding: %0d", screen_points_due.size());
      if (mismatch_count == 0 && screen_points_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
src/tsm_pkg.sv
src/tsm_csr.sv
src/tsm_axis.sv
src/touch_raw_to_screen_mapper.sv
verif/touch_raw_to_screen_mapper_tb.sv
